// ===== src/itar_pkg.sv =====
// Package for the integer-to-ASCII radix converter.
// Holds sizing constants, the op code type, the FSM state type and the digit
// character table. Depends on nothing.
package itar_pkg;

   // Width of the number as the block interprets it.
   localparam int VALUE_WIDTH = 32;

   // Fixed width of the value field on the request channel.
   localparam int FIELD_W = 32;
   localparam int CHAR_W  = 7;

   // Bits of the field that take part in the conversion.
   localparam int MASK_W = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
   localparam logic [FIELD_W-1:0] VALUE_MASK = {FIELD_W{1'b1}} >> (FIELD_W - MASK_W);
   localparam int SIGN_IDX = MASK_W - 1;
   // A value can only be negative when the sign bit lies inside the field.
   localparam bit HAS_SIGN = (VALUE_WIDTH <= FIELD_W);

   // Octal needs the most digits.
   localparam int MAX_DIGITS = (FIELD_W + 2) / 3;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W      = $clog2(MAX_DIGITS);
   localparam int DIGIT_W    = 4;

   // x / 10 == (x * RECIP_10) >> RECIP_SHIFT, exact for every 32-bit x.
   localparam int                     PROD_W      = 2 * FIELD_W;
   localparam logic [FIELD_W-1:0]     RECIP_10    = 32'hCCCC_CCCD;
   localparam int                     RECIP_SHIFT = 35;

   localparam int OCT_SHIFT = 3;
   localparam int HEX_SHIFT = 4;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

   localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
   };

   typedef enum logic [1:0] {
      OP_SDEC = 2'd0,
      OP_UDEC = 2'd1,
      OP_HEX  = 2'd2,
      OP_OCT  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIGIT,
      ST_EMIT
   } state_type;

endpackage

// ===== src/integer_to_ascii_radix.sv =====
// Integer-to-ASCII radix converter, top level; uses itar_pkg.
// Each digit takes one shared divide step: a shift for hex/octal in ST_DIGIT, and for decimal
// a reciprocal multiply in ST_MUL, then quotient and remainder in ST_DIGIT; characters then leave
// one a cycle while rsp_stall is low, a minus sign first.
// req_stall is high after an accept until the last character loads. Synchronous reset.
module integer_to_ascii_radix (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic [itar_pkg::FIELD_W-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [itar_pkg::CHAR_W-1:0]  rsp_character,
   output logic                         rsp_last
);
   import itar_pkg::*;

   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   logic                       neg_ff, neg_in;
   logic [FIELD_W-1:0]         mag_ff, mag_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [CNT_W-1:0]           nd_ff, nd_in;
   logic [DIGIT_W-1:0]         stack_ff [MAX_DIGITS];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]          rsp_char_ff, rsp_char_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       push_en;
   logic [DIGIT_W-1:0]         push_digit;
   logic [FIELD_W-1:0]         quot;
   logic [FIELD_W-1:0]         q_dec;
   logic [FIELD_W-1:0]         rem_dec;
   logic [FIELD_W-1:0]         in_mag;
   logic [IDX_W-1:0]           rd_idx;
   logic                       out_free;
   logic                       is_dec;

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_dec   = (op_ff == OP_SDEC) || (op_ff == OP_UDEC);
   assign in_mag   = req_value & VALUE_MASK;
   assign rd_idx   = IDX_W'(nd_ff - CNT_W'(1));

   // Shared divide step: quotient and remainder for the current base.
   assign q_dec   = FIELD_W'(prod_ff >> RECIP_SHIFT);
   assign rem_dec = mag_ff - ((q_dec << 3) + (q_dec << 1));

   always_comb begin
      unique case (op_ff)
         OP_HEX: begin
            quot       = mag_ff >> HEX_SHIFT;
            push_digit = mag_ff[DIGIT_W-1:0];
         end
         OP_OCT: begin
            quot       = mag_ff >> OCT_SHIFT;
            push_digit = {1'b0, mag_ff[OCT_SHIFT-1:0]};
         end
         default: begin
            quot       = q_dec;
            push_digit = rem_dec[DIGIT_W-1:0];
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      nd_in        = nd_ff;
      push_en      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = op_type'(req_op);
               nd_in  = '0;
               neg_in = 1'b0;
               mag_in = in_mag;
               if (HAS_SIGN && (op_type'(req_op) == OP_SDEC) && in_mag[SIGN_IDX]) begin
                  neg_in = 1'b1;
                  mag_in = (~in_mag + FIELD_W'(1)) & VALUE_MASK;
               end
               if ((op_type'(req_op) == OP_SDEC) || (op_type'(req_op) == OP_UDEC)) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(mag_ff) * PROD_W'(RECIP_10);
            state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            push_en = 1'b1;
            mag_in  = quot;
            nd_in   = nd_ff + CNT_W'(1);
            if (quot == '0) begin
               state_in = ST_EMIT;
            end else if (is_dec) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_char_in = CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  neg_in      = 1'b0;
               end else begin
                  rsp_char_in = DIGIT_CHARS[stack_ff[rd_idx]];
                  rsp_last_in = (nd_ff == CNT_W'(1));
                  nd_in       = nd_ff - CNT_W'(1);
                  if (nd_ff == CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         nd_ff        <= '0;
         neg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         nd_ff        <= nd_in;
         neg_ff       <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (push_en) begin
         stack_ff[nd_ff[IDX_W-1:0]] <= push_digit;
      end
   end

endmodule

// ===== src/itar_checker.sv =====
// Port-level checks for integer_to_ascii_radix, bound to the top level.
// Sees the top-level ports only; no package needed.
module itar_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_op,
   input logic [31:0] req_value,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [6:0] rsp_character,
   input logic       rsp_last
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled result changed");

   // Block is busy right after taking an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("not busy after request transfer");

   // More characters follow a non-final one without a gap.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside a number");

   // Only digits, lowercase hex letters or a minus sign appear.
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character >= 7'h30 && rsp_character <= 7'h39) ||
                    (rsp_character >= 7'h61 && rsp_character <= 7'h66) ||
                    (rsp_character == 7'h2D))
      else $error("illegal character");

   // A minus sign is never the final character.
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_character == 7'h2D) |-> !rsp_last)
      else $error("minus sign marked last");

endmodule

bind integer_to_ascii_radix itar_checker u_itar_checker (.*);
